// ===== hw/rtl/line_fold_at_last_blank_macros.svh =====
// ----------------------------------------------------------------------------
// Line fold assertion macros
// Concurrent assertion helpers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLD_AT_LAST_BLANK_MACROS_SVH
`define LINE_FOLD_AT_LAST_BLANK_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LFB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line fold assertion failed");
// next-cycle implication
`define LFB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line fold assertion failed");
`else
`define LFB_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LFB_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/lfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line fold package
// Character codes and the control/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package lfb_pkg;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_BLANK = 8'd32;

  localparam int         COL_W    = 5;
  localparam logic [4:0] COL_MAX  = 5'd31;
  localparam logic [4:0] FOLD_RST = 5'd14;

  // which parts of an output run an item produces
  typedef struct packed {
    logic lead_en;   // held blank (as blank or newline) or a hard newline
    logic drain_en;  // held characters follow
    logic tail_en;   // closing newline or the character itself
  } plan_t;

  typedef struct packed {
    logic accept;
    logic load_lead;
    logic rd;
    logic load_drain;
    logic load_tail;
  } cmd_t;

  typedef struct packed {
    logic  out_free;
    plan_t plan_in;   // plan for the word at the input
    plan_t plan_q;    // plan of the item at work
    logic  drain_last;
  } stat_t;

endpackage

// ===== hw/rtl/lfb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/lfb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line fold controller
// Sequences the output run of one item: lead word, held characters, tail.
// ----------------------------------------------------------------------------
module lfb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  lfb_pkg::stat_t stat,
  output lfb_pkg::cmd_t  cmd
);
  import lfb_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    LEAD,
    DRAIN_RD,
    DRAIN_LD,
    TAIL
  } state_t;

  state_t state;

  // where the run goes after the lead word
  function automatic state_t after_lead(plan_t p);
    if (p.drain_en) begin
      return DRAIN_RD;
    end else if (p.tail_en) begin
      return TAIL;
    end
    return IDLE;
  endfunction

  // where the run goes after the held characters
  function automatic state_t after_drain(plan_t p);
    if (p.tail_en) begin
      return TAIL;
    end
    return IDLE;
  endfunction

  // command decode
  always_comb begin
    cmd            = '0;
    cmd.accept     = (state == IDLE) && s_tvalid;
    cmd.load_lead  = (state == LEAD) && stat.out_free;
    cmd.rd         = (state == DRAIN_RD);
    cmd.load_drain = (state == DRAIN_LD) && stat.out_free;
    cmd.load_tail  = (state == TAIL) && stat.out_free;
  end

  assign s_tready = (state == IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            if (stat.plan_in.lead_en) begin
              state <= LEAD;
            end else begin
              state <= after_lead(stat.plan_in);
            end
          end
        end
        LEAD: begin
          if (stat.out_free) begin
            state <= after_lead(stat.plan_q);
          end
        end
        DRAIN_RD: begin
          state <= DRAIN_LD;
        end
        DRAIN_LD: begin
          if (stat.out_free) begin
            if (stat.drain_last) begin
              state <= after_drain(stat.plan_q);
            end else begin
              state <= DRAIN_RD;
            end
          end
        end
        TAIL: begin
          if (stat.out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/lfb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line fold datapath
// Column and hold state, fold decision, held character store, output word
// register.
// ----------------------------------------------------------------------------
module lfb_dp #(
  parameter int MAX_COLUMNS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [4:0]     cfg_wdata,
  input  logic [7:0]     s_tdata,
  input  lfb_pkg::cmd_t  cmd,
  input  logic           m_tready,
  output logic           m_tvalid,
  output logic [7:0]     m_tdata,
  output logic           m_tlast,
  output lfb_pkg::stat_t stat
);
  import lfb_pkg::*;

  localparam int PW   = $clog2(MAX_COLUMNS + 1);     // held count
  localparam int AW   = $clog2(MAX_COLUMNS);         // store address
  localparam int CMPW = ((PW > COL_W) ? PW : COL_W) + 1;

  // state
  logic [4:0]       fold_column;
  logic [COL_W-1:0] column_count;
  logic             blank_held;
  logic [PW-1:0]    pending_count;

  // item at work
  plan_t         plan_q;
  logic [7:0]    lead_char_q;
  logic [7:0]    tail_char_q;
  logic [PW-1:0] drain_n_q;
  logic [AW-1:0] rd_idx;

  logic [7:0] ram_rdata;
  logic       out_free;

  // fold decision
  logic [CMPW-1:0]  limit;
  logic [CMPW-1:0]  col_inc;
  logic [CMPW-1:0]  pc_inc;
  logic             over;
  logic             full;
  logic             is_nl;
  logic             is_blank;
  plan_t            plan_in;
  logic             lead_nl;
  logic             flush;
  logic             store;
  logic [7:0]       tail_char;
  logic [COL_W-1:0] column_count_next;
  logic             blank_held_next;
  logic [PW-1:0]    pending_count_next;
  logic             drain_last;

  function automatic logic [COL_W-1:0] sat_col(logic [CMPW-1:0] v);
    if (v > CMPW'(COL_MAX)) begin
      return COL_MAX;
    end
    return v[COL_W-1:0];
  endfunction

  // effective column limit, clamped to 1..MAX_COLUMNS
  always_comb begin
    if (fold_column == 5'd0) begin
      limit = CMPW'(1);
    end else if (CMPW'(fold_column) > CMPW'(MAX_COLUMNS)) begin
      limit = CMPW'(MAX_COLUMNS);
    end else begin
      limit = CMPW'(fold_column);
    end
  end

  assign col_inc  = CMPW'(column_count) + CMPW'(1);
  assign pc_inc   = CMPW'(pending_count) + CMPW'(1);
  assign over     = col_inc > limit;
  assign full     = blank_held && (pending_count >= PW'(MAX_COLUMNS));
  assign is_nl    = (s_tdata == CH_NL);
  assign is_blank = (s_tdata == CH_BLANK);

  // plan for the word at the input and the state it leaves
  always_comb begin
    plan_in            = '0;
    lead_nl            = 1'b0;
    flush              = 1'b0;
    store              = 1'b0;
    tail_char          = s_tdata;
    column_count_next  = column_count;
    blank_held_next    = blank_held;
    pending_count_next = pending_count;
    if (is_nl) begin
      plan_in.lead_en    = blank_held;
      flush              = 1'b1;
      plan_in.tail_en    = 1'b1;
      tail_char          = CH_NL;
      column_count_next  = '0;
      blank_held_next    = 1'b0;
      pending_count_next = '0;
    end else if (is_blank) begin
      plan_in.lead_en    = blank_held;
      flush              = 1'b1;
      pending_count_next = '0;
      if (over) begin
        // the new blank becomes the fold
        plan_in.tail_en   = 1'b1;
        tail_char         = CH_NL;
        column_count_next = '0;
        blank_held_next   = 1'b0;
      end else begin
        column_count_next = sat_col(col_inc);
        blank_held_next   = 1'b1;
      end
    end else if (over || full) begin
      plan_in.lead_en   = 1'b1;
      lead_nl           = 1'b1;
      plan_in.tail_en   = 1'b1;
      blank_held_next   = 1'b0;
      if (blank_held) begin
        // fold at the held blank, held text opens the new line
        flush              = 1'b1;
        column_count_next  = sat_col(pc_inc);
        pending_count_next = '0;
      end else begin
        // hard break
        column_count_next = COL_W'(1);
      end
    end else if (blank_held) begin
      store              = 1'b1;
      pending_count_next = pc_inc[PW-1:0];
      column_count_next  = sat_col(col_inc);
    end else begin
      plan_in.tail_en   = 1'b1;
      column_count_next = sat_col(col_inc);
    end
    plan_in.drain_en = flush && (pending_count != '0);
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      fold_column <= FOLD_RST;
    end else if (cfg_we) begin
      fold_column <= cfg_wdata;
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      blank_held    <= 1'b0;
      pending_count <= '0;
    end else if (cmd.accept) begin
      column_count  <= column_count_next;
      blank_held    <= blank_held_next;
      pending_count <= pending_count_next;
    end
  end

  // latched plan of the item at work
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      plan_q      <= plan_in;
      lead_char_q <= lead_nl ? CH_NL : CH_BLANK;
      tail_char_q <= tail_char;
      drain_n_q   <= flush ? pending_count : '0;
    end
  end

  // drain read index
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_idx <= '0;
    end else if (cmd.load_drain) begin
      rd_idx <= rd_idx + AW'(1);
    end
  end

  assign drain_last = (PW'(rd_idx) + PW'(1)) == drain_n_q;

  // held character store
  lfb_ram #(
    .WIDTH (8),
    .DEPTH (MAX_COLUMNS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.accept && store),
    .waddr (pending_count[AW-1:0]),
    .wdata (s_tdata),
    .re    (cmd.rd),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  assign out_free = !m_tvalid || m_tready;

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_lead || cmd.load_drain || cmd.load_tail) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_lead) begin
      m_tdata <= lead_char_q;
      m_tlast <= !plan_q.drain_en && !plan_q.tail_en;
    end else if (cmd.load_drain) begin
      m_tdata <= ram_rdata;
      m_tlast <= drain_last && !plan_q.tail_en;
    end else if (cmd.load_tail) begin
      m_tdata <= tail_char_q;
      m_tlast <= 1'b1;
    end
  end

  // status to controller
  always_comb begin
    stat.out_free   = out_free;
    stat.plan_in    = plan_in;
    stat.plan_q     = plan_q;
    stat.drain_last = drain_last;
  end

endmodule

// ===== hw/rtl/line_fold_at_last_blank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line fold at last blank
// Word wrap of a character stream at a set column.
// ----------------------------------------------------------------------------
// Input stream s_*: one character per word. Output stream m_*: the folded
// text, one character per word; m_tlast marks the final word caused by one
// input word. An input word may cause no output (a blank that is held, or a
// character stored behind a held blank) or up to MAX_COLUMNS + 1 words.
// cfg_we/cfg_wdata set the fold column (1..MAX_COLUMNS, 0 acts as 1, larger
// values act as MAX_COLUMNS); write it only while the block is idle.
// Sequence: an input word is accepted in IDLE; its run then steps through
// LEAD, DRAIN_RD/DRAIN_LD for each held character (store read, then output
// load) and TAIL, and each load waits for a free output register. An item
// with no output leaves the controller in IDLE. The next item is accepted
// once the last word of the run is loaded into the output register.
// Reset (synchronous, rst high) clears the column, the held blank and the
// held count, empties the output register and sets the fold column to 14.
// When the receiver stalls, the output word holds and the sequencer waits;
// s_tready stays low until the run is fully loaded.
// ----------------------------------------------------------------------------
`include "line_fold_at_last_blank_macros.svh"

module line_fold_at_last_blank #(
  parameter int MAX_COLUMNS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,   // fold_column
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,     // [7:0] in_char
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,     // [7:0] out_char
  output logic       m_tlast      // last_of_run
);
  import lfb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfb_dp #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .stat      (stat)
  );

  // a newline always produces output, so the block goes busy
  `LFB_ASSERT_NXT(a_nl_busy, clk, rst, s_tvalid && s_tready && (s_tdata == CH_NL), !s_tready)
  // words are only loaded into a free output register
  `LFB_ASSERT_IMP(a_load_free, clk, rst,
                  cmd.load_lead || cmd.load_drain || cmd.load_tail, !m_tvalid || m_tready)
  // while a run is unfinished no new input is taken
  `LFB_ASSERT_IMP(a_run_open, clk, rst, m_tvalid && !m_tlast, !s_tready)

endmodule
